### hdl/ffra_pkg.sv
// Package: shared constants and types for the first-fit region allocator.
package ffra_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int PAGE_BITS    = 12;
    localparam int ADDR_BITS    = 48;
    localparam int PNUM_BITS    = ADDR_BITS - PAGE_BITS;
    localparam int PG_W         = 36;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [1:0] KIND_RESERVE  = 2'd0;
    localparam logic [1:0] KIND_ALLOCATE = 2'd1;
    localparam logic [1:0] KIND_FREE     = 2'd2;
    localparam logic [1:0] KIND_BAD      = 2'd3;

    localparam logic [1:0] SEG_FREE      = 2'd0;
    localparam logic [1:0] SEG_RESERVED  = 2'd1;
    localparam logic [1:0] SEG_ALLOCATED = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_MAP_ERR = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_LAST  = 1'b1;

    typedef struct packed {
        logic [PG_W-1:0] start;
        logic [PG_W-1:0] last;
        logic [1:0]      kind;
    } seg_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [PG_W-1:0] region_page;
        logic            header_taken;
        logic [1:0]      headers_returned;
        logic            release_valid;
        logic [PG_W-1:0] release_page;
        logic [PG_W-1:0] release_pages;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

### hdl/ffra_seg_ram.sv
// Segment table memory: one write port, one registered read port.
module ffra_seg_ram (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ffra_pkg::IDX_W-1:0] waddr,
    input  ffra_pkg::seg_t        wdata,
    input  logic [ffra_pkg::IDX_W-1:0] raddr,
    output ffra_pkg::seg_t        rdata
);
    import ffra_pkg::*;

    seg_t mem [MAX_SEGMENTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/ffra_core.sv
// Sequencer that searches, splits, merges and shifts the segment table.
module ffra_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_sel,
    input  logic [ffra_pkg::PG_W-1:0] cfg_data,
    input  logic                   start,
    input  logic [1:0]             kind,
    input  logic [47:0]            size_bytes,
    input  logic [ffra_pkg::PG_W-1:0] free_page,
    input  logic                   header_frame_ok,
    input  logic                   map_ok,
    output logic                   busy,
    output logic                   done,
    output ffra_pkg::result_t      result
);
    import ffra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_SPLIT, S_INS_RD, S_INS_WR, S_FREE,
        S_NXT_RD, S_NXT_CHK, S_PRV_RD, S_PRV_CHK, S_DEL_RD, S_DEL_WR, S_DONE
    } state_t;

    state_t state_reg;
    logic [PG_W-1:0] first_reg, last_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg, sh_reg, del_reg;
    logic [PNUM_BITS:0] pages_reg;
    logic [1:0] kind_reg;
    logic [PG_W-1:0] fpage_reg;
    logic hok_reg, mok_reg;
    seg_t cur_reg, split_reg;
    logic prv_pend_reg;
    result_t res_reg;

    logic we;
    logic [IDX_W-1:0] waddr, raddr;
    seg_t wdata, rdata;

    ffra_seg_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [PNUM_BITS:0] req_pages;
    logic [PG_W-1:0] seg_len;
    logic init_ok;
    logic [PG_W-1:0] new_first, new_last;

    always_comb begin
        req_pages = {1'b0, size_bytes[ADDR_BITS-1:PAGE_BITS]}
                  + (PNUM_BITS+1)'(|size_bytes[PAGE_BITS-1:0]);
        if (req_pages == '0) begin
            req_pages = (PNUM_BITS+1)'(1);
        end
        seg_len = rdata.last - rdata.start + PG_W'(1);
        new_first = (cfg_we && cfg_sel == CFG_FIRST) ? cfg_data : first_reg;
        new_last  = (cfg_we && cfg_sel == CFG_LAST)  ? cfg_data : last_reg;
        init_ok = (new_first < PG_W'({PNUM_BITS{1'b1}})) && (new_first + PG_W'(1) <= new_last);
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign result = res_reg;

    always_comb begin
        we = 1'b0;
        waddr = idx_reg;
        wdata = cur_reg;
        raddr = idx_reg;
        case (state_reg)
            S_IDLE: begin
                we = cfg_we;
                waddr = '0;
                wdata = '{start: new_first + PG_W'(1), last: new_last, kind: SEG_FREE};
                raddr = '0;
            end
            S_CHK: raddr = idx_reg + IDX_W'(1);
            S_INS_RD: raddr = sh_reg - IDX_W'(1);
            S_INS_WR: begin
                we = res_reg.header_taken;
                waddr = sh_reg;
                wdata = (sh_reg == idx_reg + IDX_W'(1)) ? split_reg : rdata;
                raddr = sh_reg - IDX_W'(2);
            end
            S_FREE: begin
                we = 1'b1;
                raddr = idx_reg + IDX_W'(1);
            end
            S_NXT_RD: raddr = idx_reg + IDX_W'(1);
            S_PRV_RD: raddr = idx_reg - IDX_W'(1);
            S_DEL_RD: raddr = del_reg + IDX_W'(1);
            S_DEL_WR: begin
                we = 1'b1;
                waddr = del_reg;
                wdata = rdata;
                raddr = del_reg + IDX_W'(2);
            end
            S_DONE: begin
                we = (res_reg.status == ST_OK) || (res_reg.status == ST_MAP_ERR);
            end
            default: ;
        endcase
        if (!aresetn) begin
            we = 1'b1;
            waddr = '0;
            wdata = '{start: PG_W'(1), last: PG_W'({PNUM_BITS{1'b1}}), kind: SEG_FREE};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            first_reg <= '0;
            last_reg  <= PG_W'({PNUM_BITS{1'b1}});
            count_reg <= CNT_W'(1);
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (cfg_we) begin
                        if (cfg_sel == CFG_FIRST) first_reg <= cfg_data & PG_W'({PNUM_BITS{1'b1}});
                        else last_reg <= cfg_data & PG_W'({PNUM_BITS{1'b1}});
                        count_reg <= init_ok ? CNT_W'(1) : '0;
                    end else if (start) begin
                        kind_reg  <= kind;
                        pages_reg <= req_pages;
                        fpage_reg <= free_page;
                        hok_reg   <= header_frame_ok;
                        mok_reg   <= map_ok;
                        idx_reg   <= '0;
                        res_reg   <= '0;
                        if (kind == KIND_RESERVE || kind == KIND_ALLOCATE) begin
                            state_reg <= (count_reg == '0) ? S_DONE : S_RD;
                            res_reg.status <= (count_reg == '0) ? ST_NO_FIT : ST_OK;
                        end else if (kind == KIND_FREE) begin
                            state_reg <= (count_reg == '0) ? S_DONE : S_RD;
                            res_reg.status <= (count_reg == '0) ? ST_BAD : ST_OK;
                        end else begin
                            res_reg.status <= ST_BAD;
                            state_reg <= S_DONE;
                        end
                        cur_reg <= '0;
                    end
                end
                S_RD: state_reg <= S_CHK;
                S_CHK: begin
                    cur_reg <= rdata;
                    if (kind_reg == KIND_FREE ? (rdata.start == fpage_reg)
                        : (rdata.kind == SEG_FREE && {1'b0, seg_len} >= pages_reg)) begin
                        state_reg <= (kind_reg == KIND_FREE) ? S_FREE : S_SPLIT;
                    end else if (CNT_W'(idx_reg) + CNT_W'(1) >= count_reg) begin
                        res_reg.status <= (kind_reg == KIND_FREE) ? ST_BAD : ST_NO_FIT;
                        cur_reg <= '0;
                        idx_reg <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_SPLIT: begin
                    split_reg <= '{start: cur_reg.start + pages_reg[PG_W-1:0] + PG_W'(1),
                                   last: cur_reg.last, kind: SEG_FREE};
                    if ((cur_reg.last - cur_reg.start + PG_W'(1)) - pages_reg[PG_W-1:0]
                        >= PG_W'(2)
                        && hok_reg && count_reg < CNT_W'(MAX_SEGMENTS)) begin
                        cur_reg.last <= cur_reg.start + pages_reg[PG_W-1:0] - PG_W'(1);
                        res_reg.header_taken <= 1'b1;
                        sh_reg <= IDX_W'(count_reg);
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_INS_RD;
                    end else begin
                        state_reg <= S_INS_WR;
                        sh_reg <= '0;
                    end
                    cur_reg.kind <= (kind_reg == KIND_ALLOCATE) ? SEG_ALLOCATED : SEG_RESERVED;
                end
                S_INS_RD: begin
                    if (sh_reg == idx_reg + IDX_W'(1)) state_reg <= S_INS_WR;
                    else state_reg <= S_INS_WR;
                end
                S_INS_WR: begin
                    if (res_reg.header_taken && sh_reg != idx_reg + IDX_W'(1)) begin
                        sh_reg <= sh_reg - IDX_W'(1);
                        state_reg <= S_INS_RD;
                    end else if (kind_reg == KIND_ALLOCATE && !mok_reg) begin
                        res_reg.status <= ST_MAP_ERR;
                        state_reg <= S_FREE;
                    end else begin
                        res_reg.region_page <= cur_reg.start;
                        state_reg <= S_DONE;
                    end
                end
                S_FREE: begin
                    if (cur_reg.kind == SEG_ALLOCATED) begin
                        res_reg.release_valid <= 1'b1;
                        res_reg.release_page  <= cur_reg.start;
                        res_reg.release_pages <= cur_reg.last - cur_reg.start + PG_W'(1);
                    end
                    cur_reg.kind <= SEG_FREE;
                    state_reg <= S_NXT_RD;
                end
                S_NXT_RD: state_reg <= S_NXT_CHK;
                S_NXT_CHK: begin
                    prv_pend_reg <= 1'b1;
                    if (CNT_W'(idx_reg) + CNT_W'(1) < count_reg && rdata.kind == SEG_FREE) begin
                        cur_reg.last <= rdata.last;
                        res_reg.headers_returned <= res_reg.headers_returned + 2'd1;
                        del_reg <= idx_reg + IDX_W'(1);
                        state_reg <= S_DEL_RD;
                    end else begin
                        state_reg <= S_PRV_RD;
                    end
                end
                S_PRV_RD: state_reg <= (idx_reg == '0) ? S_DONE : S_PRV_CHK;
                S_PRV_CHK: begin
                    prv_pend_reg <= 1'b0;
                    if (rdata.kind == SEG_FREE) begin
                        cur_reg.start <= rdata.start;
                        res_reg.headers_returned <= res_reg.headers_returned + 2'd1;
                        del_reg <= idx_reg;
                        idx_reg <= idx_reg - IDX_W'(1);
                        state_reg <= S_DEL_RD;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DEL_RD: state_reg <= S_DEL_WR;
                S_DEL_WR: begin
                    if (CNT_W'(del_reg) + CNT_W'(2) >= count_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= prv_pend_reg ? S_PRV_RD : S_DONE;
                    end else begin
                        del_reg <= del_reg + IDX_W'(1);
                    end
                end
                S_DONE: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/first_fit_region_allocator_top.sv
// Top level: stream ports, output holding register and the table sequencer.
// One transfer reads the table once per segment visited during the search,
// plus a move of each entry shifted up when a split opens a slot and of
// each entry shifted down when a merge closes one. The worst case is an
// allocate that splits at the head of a nearly full 64-entry table and then
// fails its mapping; small tables take far less time. All steps go through
// the one read port and the one write port of the segment table. The input
// is not ready while a request is in work or its result has not been taken.
// Writing a heap register while idle resets the table to one free segment,
// or to an empty table if the new bounds leave no page.
module first_fit_region_allocator_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [35:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // kind[1:0], size_bytes[49:2], free_page[85:50], header_frame_ok[86], map_ok[87]
    input  logic [87:0]   s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // status[1:0], region_page[37:2], header_taken[38], headers_returned[40:39],
    // release_valid[41], release_page[77:42], release_pages[113:78], zero[119:114]
    output logic [119:0]  m_tdata
);
    import ffra_pkg::*;

    logic busy, done;
    result_t res;
    logic valid_reg;
    logic [119:0] data_reg;

    assign s_tready = !busy && !valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    ffra_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_sel(cfg_index[0]), .cfg_data(cfg_data),
        .start(s_tvalid && s_tready),
        .kind(s_tdata[1:0]), .size_bytes(s_tdata[49:2]), .free_page(s_tdata[85:50]),
        .header_frame_ok(s_tdata[86]), .map_ok(s_tdata[87]),
        .busy(busy), .done(done), .result(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (done) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            data_reg <= {6'd0, res.release_pages, res.release_page, res.release_valid,
                         res.headers_returned, res.header_taken, res.region_page, res.status};
        end
    end

endmodule

### hdl/ffra_checker.sv
// Port checker for the allocator top level, bound to it.
module ffra_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);
    import ffra_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted twice");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready with pending result");
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[37:2] == 36'd0)
        else $error("failure with region");
endmodule

bind first_fit_region_allocator_top ffra_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### dv/tb_first_fit_region_allocator_top.sv
// Testbench: directed rows and random traffic of all four kinds, checked against a predictor.
`timescale 1ns / 100ps
module tb_first_fit_region_allocator_top;
    import ffra_pkg::*;

    localparam logic [35:0] PG_MAX  = 36'hF_FFFF_FFFF;
    localparam int          N_GROUPS = 7;
    localparam int          GROUP_ITEMS = 265;

    typedef struct {
        logic [1:0]  kind;
        logic [47:0] size;
        logic [35:0] page;
        bit          hdr_ok;
        bit          map_ok;
        bit          typed;
        result_t     res;
    } dir_row_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_we;
    logic [0:0]    cfg_index;
    logic [35:0]   cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [87:0]   s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [119:0]  m_tdata;

    first_fit_region_allocator_top uut (.*);

    logic [35:0]   heap_lo, heap_hi;
    logic [35:0]   tbl_start [MAX_SEGMENTS];
    logic [35:0]   tbl_end   [MAX_SEGMENTS];
    logic [1:0]    tbl_kind  [MAX_SEGMENTS];
    int            tbl_count;
    result_t       pending_results[$];
    int            errors;
    int            tx_idle, rx_idle;

    dir_row_t dir_rows[14] = '{
        '{KIND_RESERVE,  48'd0,          36'd0, 1, 1, 1,
          '{ST_OK, 36'd1, 1'b1, 2'd0, 1'b0, 36'd0, 36'd0}},
        '{KIND_FREE,     48'd0,          36'd7, 1, 1, 1,
          '{ST_BAD, 36'd0, 1'b0, 2'd0, 1'b0, 36'd0, 36'd0}},
        '{KIND_BAD,      48'hFFFF_FFFF_FFFF, PG_MAX, 1, 1, 1,
          '{ST_BAD, 36'd0, 1'b0, 2'd0, 1'b0, 36'd0, 36'd0}},
        '{KIND_ALLOCATE, 48'hFFFF_FFFF_FFFF, 36'd0, 1, 1, 1,
          '{ST_NO_FIT, 36'd0, 1'b0, 2'd0, 1'b0, 36'd0, 36'd0}},
        '{KIND_ALLOCATE, 48'd8193,       36'd0, 1, 0, 1,
          '{ST_MAP_ERR, 36'd0, 1'b1, 2'd1, 1'b1, 36'd3, 36'd3}},
        '{KIND_ALLOCATE, 48'd4096,       36'd0, 1, 1, 0, '0},
        '{KIND_RESERVE,  48'd8192,       36'd0, 0, 1, 0, '0},
        '{KIND_FREE,     48'd0,          36'd3, 0, 0, 0, '0},
        '{KIND_FREE,     48'd0,          36'd3, 1, 1, 0, '0},
        '{KIND_FREE,     48'd0,          36'd1, 1, 1, 0, '0},
        '{KIND_FREE,     48'd0,          36'd5, 0, 1, 0, '0},
        '{KIND_RESERVE,  48'd1,          36'd0, 1, 0, 0, '0},
        '{KIND_ALLOCATE, 48'd4097,       36'd0, 1, 1, 0, '0},
        '{KIND_FREE,     48'd0,          36'd1, 1, 1, 0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("first_fit_region_allocator_top verification failed");
        $finish;
    end

    function automatic void table_reset();
        tbl_count = 0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            tbl_start[i] = '0;
            tbl_end[i]   = '0;
            tbl_kind[i]  = SEG_FREE;
        end
        if (heap_lo == PG_MAX || heap_lo + 37'd1 > {1'b0, heap_hi})
            return;
        tbl_start[0] = heap_lo + 36'd1;
        tbl_end[0]   = heap_hi;
        tbl_count    = 1;
    endfunction

    function automatic void drop_entry(int i);
        for (int j = i; j < tbl_count - 1; j++) begin
            tbl_start[j] = tbl_start[j+1];
            tbl_end[j]   = tbl_end[j+1];
            tbl_kind[j]  = tbl_kind[j+1];
        end
        tbl_count--;
    endfunction

    function automatic void release_and_merge(int i, ref result_t r);
        if (tbl_kind[i] == SEG_ALLOCATED) begin
            r.release_valid = 1'b1;
            r.release_page  = tbl_start[i];
            r.release_pages = tbl_end[i] - tbl_start[i] + 36'd1;
        end
        tbl_kind[i] = SEG_FREE;
        if (i + 1 < tbl_count && tbl_kind[i+1] == SEG_FREE) begin
            tbl_end[i] = tbl_end[i+1];
            drop_entry(i + 1);
            r.headers_returned++;
        end
        if (i > 0 && tbl_kind[i-1] == SEG_FREE) begin
            tbl_end[i-1] = tbl_end[i];
            drop_entry(i);
            r.headers_returned++;
        end
    endfunction

    function automatic result_t allocator_step(logic [1:0] kind, logic [47:0] size,
                                               logic [35:0] page, bit hdr_ok, bit map_ok);
        result_t     r;
        longint unsigned pages, seg_len;
        int          i;
        r = '0;
        if (kind == KIND_RESERVE || kind == KIND_ALLOCATE) begin
            pages = 64'(size[47:12]) + 64'(|size[11:0]);
            if (pages == 0)
                pages = 1;
            for (i = 0; i < tbl_count; i++)
                if (tbl_kind[i] == SEG_FREE && tbl_end[i] - tbl_start[i] + 64'd1 >= pages)
                    break;
            if (i >= tbl_count) begin
                r.status = ST_NO_FIT;
                return r;
            end
            seg_len = tbl_end[i] - tbl_start[i] + 64'd1;
            if (seg_len - pages >= 2 && hdr_ok && tbl_count < MAX_SEGMENTS) begin
                for (int j = tbl_count; j > i + 1; j--) begin
                    tbl_start[j] = tbl_start[j-1];
                    tbl_end[j]   = tbl_end[j-1];
                    tbl_kind[j]  = tbl_kind[j-1];
                end
                tbl_count++;
                tbl_start[i+1] = 36'(tbl_start[i] + pages + 1);
                tbl_end[i+1]   = tbl_end[i];
                tbl_kind[i+1]  = SEG_FREE;
                tbl_end[i]     = 36'(tbl_start[i] + pages - 1);
                r.header_taken = 1'b1;
            end
            tbl_kind[i] = (kind == KIND_ALLOCATE) ? SEG_ALLOCATED : SEG_RESERVED;
            if (kind == KIND_ALLOCATE && !map_ok) begin
                release_and_merge(i, r);
                r.status = ST_MAP_ERR;
                return r;
            end
            r.status      = ST_OK;
            r.region_page = tbl_start[i];
            return r;
        end
        if (kind == KIND_FREE) begin
            for (i = 0; i < tbl_count; i++)
                if (tbl_start[i] == page)
                    break;
            if (i >= tbl_count) begin
                r.status = ST_BAD;
                return r;
            end
            release_and_merge(i, r);
            r.status = ST_OK;
            return r;
        end
        r.status = ST_BAD;
        return r;
    endfunction

    task automatic send_request(logic [1:0] kind, logic [47:0] size, logic [35:0] page,
                                bit hdr_ok, bit map_ok, bit typed, result_t typed_res);
        result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {map_ok, hdr_ok, page, size, kind};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        r = allocator_step(kind, size, page, hdr_ok, map_ok);
        pending_results.push_back(typed ? typed_res : r);
        if ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic write_heap(logic [35:0] lo, logic [35:0] hi);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_index <= CFG_LAST;
        cfg_data  <= hi;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        heap_lo = lo;
        heap_hi = hi;
        table_reset();
        @(posedge aclk);
    endtask

    initial begin : receiver
        logic          got;
        logic [119:0]  d;
        result_t       act, exp_r;
        forever begin
            @(negedge aclk);
            got = m_tvalid && m_tready && aresetn;
            d   = m_tdata;
            @(posedge aclk);
            if (got) begin
                act = '{d[1:0], d[37:2], d[38], d[40:39], d[41], d[77:42], d[113:78]};
                if (pending_results.size() == 0) begin
                    $display("%t unexpected result %h", $time, d);
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (act.status != exp_r.status) begin
                        $display("%t status exp %0d got %0d", $time, exp_r.status, act.status);
                        errors++;
                    end
                    if (act.region_page != exp_r.region_page) begin
                        $display("%t region_page exp %h got %h", $time,
                                 exp_r.region_page, act.region_page);
                        errors++;
                    end
                    if (act.header_taken != exp_r.header_taken) begin
                        $display("%t header_taken exp %0d got %0d", $time,
                                 exp_r.header_taken, act.header_taken);
                        errors++;
                    end
                    if (act.headers_returned != exp_r.headers_returned) begin
                        $display("%t headers_returned exp %0d got %0d", $time,
                                 exp_r.headers_returned, act.headers_returned);
                        errors++;
                    end
                    if (act.release_valid != exp_r.release_valid) begin
                        $display("%t release_valid exp %0d got %0d", $time,
                                 exp_r.release_valid, act.release_valid);
                        errors++;
                    end
                    if (act.release_page != exp_r.release_page) begin
                        $display("%t release_page exp %h got %h", $time,
                                 exp_r.release_page, act.release_page);
                        errors++;
                    end
                    if (act.release_pages != exp_r.release_pages) begin
                        $display("%t release_pages exp %h got %h", $time,
                                 exp_r.release_pages, act.release_pages);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin : stimulus
        logic [1:0]  kind;
        logic [47:0] size;
        logic [35:0] page;
        int          mode, sel;
        errors    = 0;
        tx_idle   = 29;
        rx_idle   = 77;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FIRST;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        heap_lo   = '0;
        heap_hi   = PG_MAX;
        table_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k])
            send_request(dir_rows[k].kind, dir_rows[k].size, dir_rows[k].page,
                         dir_rows[k].hdr_ok, dir_rows[k].map_ok, dir_rows[k].typed,
                         dir_rows[k].res);

        for (int g = 0; g < N_GROUPS; g++) begin
            mode = g * 3 / N_GROUPS;
            tx_idle = (mode == 0) ? 29 : (mode == 1) ? 77 : 0;
            rx_idle = (mode == 0) ? 77 : (mode == 1) ? 29 : 0;
            case (g)
                1: write_heap(36'd100, 36'd160);
                2: write_heap(PG_MAX - 36'd1, PG_MAX);
                3: write_heap(36'd0, 36'd0);
                4: write_heap(PG_MAX, PG_MAX);
                5: write_heap(36'd7, PG_MAX);
                6: write_heap(36'd20, 36'd300);
                default: ;
            endcase
            for (int n = 0; n < GROUP_ITEMS; n++) begin
                sel = $urandom_range(99);
                if (sel < 45)
                    kind = KIND_ALLOCATE - ($urandom_range(1) ? 2'd1 : 2'd0);
                else if (sel < 95)
                    kind = KIND_FREE;
                else
                    kind = KIND_BAD;
                if ($urandom_range(19) == 0)
                    size = 48'({$urandom, $urandom});
                else
                    size = 48'($urandom_range(0, 5 * 4096));
                if (tbl_count > 0 && $urandom_range(9) < 8)
                    page = tbl_start[$urandom_range(tbl_count - 1)];
                else if ($urandom_range(1))
                    page = heap_lo + $urandom_range(0, 400);
                else
                    page = 36'({$urandom, $urandom});
                send_request(kind, size, page, $urandom_range(9) != 0,
                             $urandom_range(9) != 0, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("first_fit_region_allocator_top verification clean");
        else
            $display("first_fit_region_allocator_top verification failed");
        $finish;
    end

endmodule
